[rtl/assert_macros.svh]
// Assertion macros shared by the motor guard RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dmss_pkg.sv]
// Shared types, constants and codes of the dual motor soft-start and stall guard.
`timescale 1ns / 1ps

package dmss_pkg;

    // Parameter defaults
    localparam int DutyMaxDef   = 10000;
    localparam int SpeedFracDef = 4;

    // Field widths
    localparam int MagW   = 14;
    localparam int CmdW   = 16;
    localparam int StepW  = 10;
    localparam int CntW   = 7;
    localparam int SpeedW = 16;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    // Register reset values
    localparam logic [MagW-1:0]  OutLimRst     = 14'd9000;
    localparam logic [MagW-1:0]  SecLimRst     = 14'd0;
    localparam logic [MagW-1:0]  RampInitRst   = 14'd3000;
    localparam logic [StepW-1:0] RampStepRst   = 10'd48;
    localparam logic [MagW-1:0]  StallDutyRst  = 14'd6000;
    localparam int               StallSpeedInt = 2;
    localparam logic [CntW-1:0]  ConfirmRst    = 7'd80;
    localparam logic [MagW-1:0]  StopDutyRst   = 14'd100;

    localparam logic [CntW-1:0]  CntMax = 7'd127;

    // Item operation codes
    localparam logic [1:0] OpDrive = 2'd0;
    localparam logic [1:0] OpStall = 2'd1;
    localparam logic [1:0] OpStop  = 2'd2;

    // Register indexes
    localparam logic [2:0] RegOutLim    = 3'd0;
    localparam logic [2:0] RegSecLim    = 3'd1;
    localparam logic [2:0] RegRampInit  = 3'd2;
    localparam logic [2:0] RegRampStep  = 3'd3;
    localparam logic [2:0] RegStallDuty = 3'd4;
    localparam logic [2:0] RegStallSpd  = 3'd5;
    localparam logic [2:0] RegConfirm   = 3'd6;
    localparam logic [2:0] RegStopDuty  = 3'd7;

    typedef struct packed {
        logic [MagW-1:0]   output_limit;
        logic [MagW-1:0]   second_limit;
        logic [MagW-1:0]   ramp_initial;
        logic [StepW-1:0]  ramp_step;
        logic [MagW-1:0]   stall_duty_threshold;
        logic [SpeedW-1:0] stall_speed_threshold;
        logic [CntW-1:0]   stall_confirm;
        logic [MagW-1:0]   stop_duty;
    } t_cfg;

    // Request to the multiply-divide unit: quo = mag * lim / div
    typedef struct packed {
        logic            start;
        logic [MagW-1:0] mag;
        logic [MagW-1:0] lim;
        logic [MagW-1:0] div;
    } t_md_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [MagW-1:0] quo;
    } t_md_rsp;

endpackage

[rtl/dmss_cfg_regs.sv]
// Configuration register bank with APB-style access.
`timescale 1ns / 1ps

module dmss_cfg_regs #(
    parameter int SPEED_FRAC_BITS = dmss_pkg::SpeedFracDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dmss_pkg::AddrW-1:0] paddr,
    input  logic [dmss_pkg::DataW-1:0] pwdata,
    output logic [dmss_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output dmss_pkg::t_cfg             o_cfg
);

    localparam logic [dmss_pkg::SpeedW-1:0] SstRst =
        16'(dmss_pkg::StallSpeedInt << SPEED_FRAC_BITS);

    logic [dmss_pkg::MagW-1:0]   r_out_lim;
    logic [dmss_pkg::MagW-1:0]   r_sec_lim;
    logic [dmss_pkg::MagW-1:0]   r_ramp_init;
    logic [dmss_pkg::StepW-1:0]  r_ramp_step;
    logic [dmss_pkg::MagW-1:0]   r_stall_duty;
    logic [dmss_pkg::SpeedW-1:0] r_stall_spd;
    logic [dmss_pkg::CntW-1:0]   r_confirm;
    logic [dmss_pkg::MagW-1:0]   r_stop_duty;
    logic [2:0]                  w_idx;
    logic                        w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_lim    <= dmss_pkg::OutLimRst;
            r_sec_lim    <= dmss_pkg::SecLimRst;
            r_ramp_init  <= dmss_pkg::RampInitRst;
            r_ramp_step  <= dmss_pkg::RampStepRst;
            r_stall_duty <= dmss_pkg::StallDutyRst;
            r_stall_spd  <= SstRst;
            r_confirm    <= dmss_pkg::ConfirmRst;
            r_stop_duty  <= dmss_pkg::StopDutyRst;
        end else if (w_wr) begin
            unique case (w_idx)
                dmss_pkg::RegOutLim:    r_out_lim    <= pwdata[13:0];
                dmss_pkg::RegSecLim:    r_sec_lim    <= pwdata[13:0];
                dmss_pkg::RegRampInit:  r_ramp_init  <= pwdata[13:0];
                dmss_pkg::RegRampStep:  r_ramp_step  <= pwdata[9:0];
                dmss_pkg::RegStallDuty: r_stall_duty <= pwdata[13:0];
                dmss_pkg::RegStallSpd:  r_stall_spd  <= pwdata[15:0];
                dmss_pkg::RegConfirm:   r_confirm    <= pwdata[6:0];
                dmss_pkg::RegStopDuty:  r_stop_duty  <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            dmss_pkg::RegOutLim:    prdata = {18'd0, r_out_lim};
            dmss_pkg::RegSecLim:    prdata = {18'd0, r_sec_lim};
            dmss_pkg::RegRampInit:  prdata = {18'd0, r_ramp_init};
            dmss_pkg::RegRampStep:  prdata = {22'd0, r_ramp_step};
            dmss_pkg::RegStallDuty: prdata = {18'd0, r_stall_duty};
            dmss_pkg::RegStallSpd:  prdata = {16'd0, r_stall_spd};
            dmss_pkg::RegConfirm:   prdata = {25'd0, r_confirm};
            dmss_pkg::RegStopDuty:  prdata = {18'd0, r_stop_duty};
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.output_limit          = r_out_lim;
        o_cfg.second_limit          = r_sec_lim;
        o_cfg.ramp_initial          = r_ramp_init;
        o_cfg.ramp_step             = r_ramp_step;
        o_cfg.stall_duty_threshold  = r_stall_duty;
        o_cfg.stall_speed_threshold = r_stall_spd;
        o_cfg.stall_confirm         = r_confirm;
        o_cfg.stop_duty             = r_stop_duty;
    end

endmodule

[rtl/dmss_muldiv.sv]
// Shared multiply then restoring divide unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmss_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmss_pkg::t_md_req i_req,
    output dmss_pkg::t_md_rsp o_rsp
);

    localparam int MW   = dmss_pkg::MagW;
    localparam int CntB = $clog2(MW + 1);
    localparam logic [CntB-1:0] LastStep = CntB'(MW - 1);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]      r_state;
    logic [MW-1:0]   r_a;
    logic [MW-1:0]   r_b;
    logic [MW-1:0]   r_d;
    logic [MW-1:0]   r_rem;
    logic [MW-1:0]   r_q;
    logic [CntB-1:0] r_cnt;
    logic            r_done;
    logic [2*MW-1:0] w_prod;
    logic [MW+1:0]   w_trial;
    logic            w_fit;

    assign w_prod  = r_a * r_b;
    // Shift in the next dividend bit and try the subtract
    assign w_trial = {1'b0, r_rem, r_q[MW-1]} - {2'b00, r_d};
    assign w_fit   = !w_trial[MW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_a     <= i_req.mag;
                        r_b     <= i_req.lim;
                        r_d     <= i_req.div;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    // Quotient fits MW bits, so the upper half already lies below the divisor
                    r_rem   <= w_prod[2*MW-1:MW];
                    r_q     <= w_prod[MW-1:0];
                    r_cnt   <= '0;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    r_rem <= w_fit ? w_trial[MW-1:0] : {r_rem[MW-2:0], r_q[MW-1]};
                    r_q   <= {r_q[MW-2:0], w_fit};
                    r_cnt <= r_cnt + CntB'(1);
                    if (r_cnt == LastStep) begin
                        r_state <= U_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != U_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == U_DIV, r_rem < r_d, "remainder not below divisor")
    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == U_IDLE, "start while unit busy")
    `ASSERT_NEXT(a_done_after_div, i_clk, i_rst_n, (r_state == U_DIV) && (r_cnt == LastStep), r_done && (r_state == U_IDLE), "divide did not finish")

endmodule

[rtl/dual_motor_soft_start_stall_guard_core.sv]
// Top level of the dual motor soft-start and stall guard: sequencer, state and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One item at a time. o_in_ready is high only while the sequencer is idle; an accepted
// item is finished into a result register, so the next item can be taken while that
// result still waits for i_out_ready. Stall ticks, stop requests and drive commands
// while stopped go from acceptance straight to the finish step. A drive command that
// needs no scaling passes the check step once for each limit before finishing. Each
// active limit (soft-start ramp, then the second limit) costs two passes through the
// shared multiply-divide unit, left side then right; each pass loads the operands,
// multiplies, then forms 14 quotient bits at one bit a cycle. A result still waiting
// for i_out_ready holds the next item at its finish step until the result register
// frees up. The scaled magnitude is |cmd| * limit / max(|left|, |right|), truncated
// toward zero, with the sign restored afterwards. Configuration is an APB-style bank
// of eight 32-bit words at byte addresses 0 to 28; write it only while the
// block is idle.

module dual_motor_soft_start_stall_guard_core #(
    parameter int DUTY_MAX        = dmss_pkg::DutyMaxDef,
    parameter int SPEED_FRAC_BITS = dmss_pkg::SpeedFracDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmss_pkg::AddrW-1:0]  paddr,
    input  logic [dmss_pkg::DataW-1:0]  pwdata,
    output logic [dmss_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic signed [15:0]          i_left_cmd,
    input  logic signed [15:0]          i_right_cmd,
    input  logic signed [15:0]          i_left_speed,
    input  logic signed [15:0]          i_right_speed,
    // result item channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [13:0]                 o_left_duty,
    output logic                        o_left_dir_pin,
    output logic [13:0]                 o_right_duty,
    output logic                        o_right_dir_pin,
    output logic                        o_stopped,
    output logic                        o_stall_trip,
    output logic [13:0]                 o_ramp_now
);

    localparam int MW = dmss_pkg::MagW;
    localparam logic [16:0] DutyMaxW = 17'(DUTY_MAX);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIVL = 3'd2;
    localparam logic [2:0] S_DIVR = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    dmss_pkg::t_cfg    cfg;
    dmss_pkg::t_md_req md_req;
    dmss_pkg::t_md_rsp md_rsp;

    // Sequencer and item registers
    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic [15:0]   r_lspd;
    logic [15:0]   r_rspd;
    logic [MW-1:0] r_lmag;
    logic [MW-1:0] r_rmag;
    logic          r_lneg;
    logic          r_rneg;
    logic          r_phase;
    logic [MW-1:0] r_mx;
    logic [MW-1:0] r_lim;

    // Block state
    logic [MW-1:0] r_ramp;
    logic [MW-1:0] r_last_l;
    logic [MW-1:0] r_last_r;
    logic [6:0]    r_lcnt;
    logic [6:0]    r_rcnt;
    logic          r_stop;
    logic          r_lpin;
    logic          r_rpin;
    logic [MW-1:0] r_lduty;
    logic [MW-1:0] r_rduty;

    // Result register
    logic          r_out_valid;
    logic [MW-1:0] r_o_lduty;
    logic          r_o_lpin;
    logic [MW-1:0] r_o_rduty;
    logic          r_o_rpin;
    logic          r_o_stopped;
    logic          r_o_trip;
    logic [MW-1:0] r_o_ramp;

    // Next values at the finish step
    logic [MW-1:0] n_ramp;
    logic [MW-1:0] n_last_l;
    logic [MW-1:0] n_last_r;
    logic [6:0]    n_lcnt;
    logic [6:0]    n_rcnt;
    logic          n_stop;
    logic          n_lpin;
    logic          n_rpin;
    logic [MW-1:0] n_lduty;
    logic [MW-1:0] n_rduty;
    logic          n_trip;

    logic [MW-1:0] w_olim;
    logic [MW-1:0] w_stopd;
    logic [14:0]   w_lclamp;
    logic [14:0]   w_rclamp;
    logic [MW-1:0] w_lim;
    logic [MW-1:0] w_mx;
    logic          w_need;
    logic [MW:0]   w_rsum;
    logic          w_out_free;
    logic          w_commit;
    logic          w_lstall;
    logic          w_rstall;
    logic [6:0]    w_lcnt_inc;
    logic [6:0]    w_rcnt_inc;

    // Clamp a signed command to +/- lim; returns {sign, magnitude}
    function automatic logic [14:0] clamp_cmd(input logic [15:0] cmd, input logic [13:0] lim);
        logic [16:0] ext;
        logic [16:0] mag;
        ext = {cmd[15], cmd};
        mag = cmd[15] ? (~ext + 17'd1) : ext;
        if (mag > {3'b000, lim}) begin
            clamp_cmd = {cmd[15], lim};
        end else begin
            clamp_cmd = {cmd[15], mag[13:0]};
        end
    endfunction

    dmss_cfg_regs #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dmss_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // Saturate the output limit and the stop duty at DUTY_MAX
    assign w_olim  = ({3'b000, cfg.output_limit} > DutyMaxW) ? DutyMaxW[MW-1:0]
                                                             : cfg.output_limit;
    assign w_stopd = ({3'b000, cfg.stop_duty} > DutyMaxW) ? DutyMaxW[MW-1:0]
                                                          : cfg.stop_duty;

    assign w_lclamp = clamp_cmd(i_left_cmd, w_olim);
    assign w_rclamp = clamp_cmd(i_right_cmd, w_olim);

    // Pass 0 checks the ramp, pass 1 the second limit; a zero limit is skipped
    assign w_lim  = r_phase ? cfg.second_limit : r_ramp;
    assign w_mx   = (r_lmag > r_rmag) ? r_lmag : r_rmag;
    assign w_need = (w_lim != '0) && (w_mx > w_lim);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_FIN) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE);

    // Hand the left side to the unit from the check step, the right side once left is back
    always_comb begin
        md_req = '0;
        if (r_state == S_CHK && w_need) begin
            md_req.start = 1'b1;
            md_req.mag   = r_lmag;
            md_req.lim   = w_lim;
            md_req.div   = w_mx;
        end else if (r_state == S_DIVL && md_rsp.done) begin
            md_req.start = 1'b1;
            md_req.mag   = r_rmag;
            md_req.lim   = r_lim;
            md_req.div   = r_mx;
        end
    end

    assign w_rsum   = {1'b0, r_ramp} + {5'd0, cfg.ramp_step};
    assign w_lstall = (r_last_l > cfg.stall_duty_threshold)
                   && ($signed(r_lspd) < $signed(cfg.stall_speed_threshold));
    assign w_rstall = (r_last_r > cfg.stall_duty_threshold)
                   && ($signed(r_rspd) < $signed(cfg.stall_speed_threshold));
    assign w_lcnt_inc = w_lstall ? ((r_lcnt == dmss_pkg::CntMax) ? r_lcnt : r_lcnt + 7'd1)
                                 : 7'd0;
    assign w_rcnt_inc = w_rstall ? ((r_rcnt == dmss_pkg::CntMax) ? r_rcnt : r_rcnt + 7'd1)
                                 : 7'd0;

    // Work out the state after this item from the finished operands
    always_comb begin
        n_ramp   = r_ramp;
        n_last_l = r_last_l;
        n_last_r = r_last_r;
        n_lcnt   = r_lcnt;
        n_rcnt   = r_rcnt;
        n_stop   = r_stop;
        n_lpin   = r_lpin;
        n_rpin   = r_rpin;
        n_lduty  = r_lduty;
        n_rduty  = r_rduty;
        n_trip   = 1'b0;
        unique case (r_op)
            dmss_pkg::OpDrive: begin
                if (r_stop) begin
                    // Stopped: drive the stop duty, leave everything else alone
                    n_lduty = w_stopd;
                    n_rduty = w_stopd;
                end else begin
                    if (r_lmag == '0 && r_rmag == '0) begin
                        n_ramp = cfg.ramp_initial;
                        n_lcnt = '0;
                        n_rcnt = '0;
                    end else if (r_ramp < w_olim) begin
                        n_ramp = (w_rsum > {1'b0, w_olim}) ? w_olim : w_rsum[MW-1:0];
                    end
                    n_last_l = r_lmag;
                    n_last_r = r_rmag;
                    if (r_lmag != '0) begin
                        n_lpin = !r_lneg;
                    end
                    if (r_rmag != '0) begin
                        n_rpin = r_rneg;
                    end
                    n_lduty = r_lmag;
                    n_rduty = r_rmag;
                end
            end
            dmss_pkg::OpStall: begin
                if (r_ramp < cfg.stall_duty_threshold) begin
                    // Ramp still low: clear the counters only
                    n_lcnt = '0;
                    n_rcnt = '0;
                end else if (w_lcnt_inc >= cfg.stall_confirm
                          || w_rcnt_inc >= cfg.stall_confirm) begin
                    n_stop = 1'b1;
                    n_trip = 1'b1;
                    n_lcnt = '0;
                    n_rcnt = '0;
                end else begin
                    n_lcnt = w_lcnt_inc;
                    n_rcnt = w_rcnt_inc;
                end
            end
            dmss_pkg::OpStop: begin
                n_stop = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_ramp      <= dmss_pkg::RampInitRst;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_lcnt      <= '0;
            r_rcnt      <= '0;
            r_stop      <= 1'b0;
            r_lpin      <= 1'b0;
            r_rpin      <= 1'b1;
            r_lduty     <= '0;
            r_rduty     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        // Take the item; clamp the commands on the way in
                        r_op    <= i_op;
                        r_lspd  <= i_left_speed;
                        r_rspd  <= i_right_speed;
                        r_lneg  <= w_lclamp[14];
                        r_lmag  <= w_lclamp[MW-1:0];
                        r_rneg  <= w_rclamp[14];
                        r_rmag  <= w_rclamp[MW-1:0];
                        r_phase <= 1'b0;
                        r_state <= (i_op == dmss_pkg::OpDrive && !r_stop) ? S_CHK : S_FIN;
                    end
                end
                S_CHK: begin
                    if (w_need) begin
                        r_mx    <= w_mx;
                        r_lim   <= w_lim;
                        r_state <= S_DIVL;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIVL: begin
                    if (md_rsp.done) begin
                        r_lmag  <= md_rsp.quo;
                        r_state <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (md_rsp.done) begin
                        r_rmag <= md_rsp.quo;
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_CHK;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    // Hold here until the result register is free, then commit once
                    if (w_out_free) begin
                        r_ramp   <= n_ramp;
                        r_last_l <= n_last_l;
                        r_last_r <= n_last_r;
                        r_lcnt   <= n_lcnt;
                        r_rcnt   <= n_rcnt;
                        r_stop   <= n_stop;
                        r_lpin   <= n_lpin;
                        r_rpin   <= n_rpin;
                        r_lduty  <= n_lduty;
                        r_rduty  <= n_rduty;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded only on commit
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_lduty   <= n_lduty;
            r_o_lpin    <= n_lpin;
            r_o_rduty   <= n_rduty;
            r_o_rpin    <= n_rpin;
            r_o_stopped <= n_stop;
            r_o_trip    <= n_trip;
            r_o_ramp    <= n_ramp;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_duty     = r_o_lduty;
    assign o_left_dir_pin  = r_o_lpin;
    assign o_right_duty    = r_o_rduty;
    assign o_right_dir_pin = r_o_rpin;
    assign o_stopped       = r_o_stopped;
    assign o_stall_trip    = r_o_trip;
    assign o_ramp_now      = r_o_ramp;

    `ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stop, r_stop, "stop latch cleared without reset")
    `ASSERT_IMPL(a_trip_stops, i_clk, i_rst_n, r_out_valid && r_o_trip, r_o_stopped, "trip result without stop")
    `ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, md_rsp.done, r_state == S_DIVL || r_state == S_DIVR, "quotient arrived outside a divide step")
    `ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, md_rsp.busy, !o_in_ready, "ready while unit busy")

endmodule

[sim/dual_motor_soft_start_stall_guard_core_tb.sv]
// Self-checking testbench for the dual motor soft-start and stall guard core.
`timescale 1ns / 1ps

module dual_motor_soft_start_stall_guard_core_tb;

    // Op code 3 has no package name: the block reports state and changes nothing.
    localparam logic [1:0] OpUnused   = 2'd3;
    localparam int         DUTY_LIMIT = dmss_pkg::DutyMaxDef;
    localparam int         CYCLE_CAP  = 400000;
    localparam int         HOLD_LEN   = 300;
    localparam int         CLEAR_RUN  = 20;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] lcmd;
        logic signed [15:0] rcmd;
        logic signed [15:0] lspd;
        logic signed [15:0] rspd;
    } t_guard_item;

    typedef struct packed {
        logic [13:0] left_duty;
        logic        left_dir;
        logic [13:0] right_duty;
        logic        right_dir;
        logic        stopped;
        logic        trip;
        logic [13:0] ramp;
    } t_guard_res;

    // DUT pins; the inputs start at known values from time zero
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [dmss_pkg::AddrW-1:0]    paddr         = '0;
    logic [dmss_pkg::DataW-1:0]    pwdata        = '0;
    logic [dmss_pkg::DataW-1:0]    prdata;
    logic                          pready;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_op          = dmss_pkg::OpDrive;
    logic signed [15:0]            i_left_cmd    = '0;
    logic signed [15:0]            i_right_cmd   = '0;
    logic signed [15:0]            i_left_speed  = '0;
    logic signed [15:0]            i_right_speed = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic [13:0]                   o_left_duty;
    logic                          o_left_dir_pin;
    logic [13:0]                   o_right_duty;
    logic                          o_right_dir_pin;
    logic                          o_stopped;
    logic                          o_stall_trip;
    logic [13:0]                   o_ramp_now;

    // Shadow of the register bank, starting from the reset values
    dmss_pkg::t_cfg cfg_now = '{
        output_limit:          dmss_pkg::OutLimRst,
        second_limit:          dmss_pkg::SecLimRst,
        ramp_initial:          dmss_pkg::RampInitRst,
        ramp_step:             dmss_pkg::RampStepRst,
        stall_duty_threshold:  dmss_pkg::StallDutyRst,
        stall_speed_threshold: 16'(dmss_pkg::StallSpeedInt << dmss_pkg::SpeedFracDef),
        stall_confirm:         dmss_pkg::ConfirmRst,
        stop_duty:             dmss_pkg::StopDutyRst
    };

    // Predicted guard state, at its reset values
    logic [13:0]        g_ramp   = dmss_pkg::RampInitRst;
    logic signed [14:0] g_last_l = '0;
    logic signed [14:0] g_last_r = '0;
    logic [6:0]         g_cnt_l  = '0;
    logic [6:0]         g_cnt_r  = '0;
    logic               g_stop   = 1'b0;
    logic               g_pin_l  = 1'b0;
    logic               g_pin_r  = 1'b1;
    logic [13:0]        g_duty_l = '0;
    logic [13:0]        g_duty_r = '0;

    t_guard_item cmd_backlog[$];   // items waiting to be offered
    t_guard_res  outputs_due[$];   // predicted results, oldest first
    t_guard_item tx_item;
    t_guard_item rx_in;
    t_guard_res  rx_want;

    int  n_issued     = 0;
    int  n_accepted   = 0;
    int  n_checked    = 0;
    int  n_drive      = 0;
    int  n_tick       = 0;
    int  n_stop_req   = 0;
    int  n_unused     = 0;
    int  n_trips      = 0;
    int  err_count    = 0;
    int  since_clear  = 0;
    bit  keep_clear   = 1'b1;
    logic in_taken    = 1'b0;
    int  tx_burst     = 1;
    int  tx_gap       = 0;
    int  rx_cycle     = 0;
    int  rx_mode      = 0;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;
    int  hold_left    = 0;
    int  cycles       = 0;

    dual_motor_soft_start_stall_guard_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_left_cmd      (i_left_cmd),
        .i_right_cmd     (i_right_cmd),
        .i_left_speed    (i_left_speed),
        .i_right_speed   (i_right_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_left_duty     (o_left_duty),
        .o_left_dir_pin  (o_left_dir_pin),
        .o_right_duty    (o_right_duty),
        .o_right_dir_pin (o_right_dir_pin),
        .o_stopped       (o_stopped),
        .o_stall_trip    (o_stall_trip),
        .o_ramp_now      (o_ramp_now)
    );

    // 10 ns clock: rising edges at 5, 15, 25 ...
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the guard state by one item and return the result it produces.
    function automatic t_guard_res guard_advance(input t_guard_item it);
        t_guard_res res;
        int   olim, sd, l, r, la, ra, mx, lim, grown, spd_thr, k;
        logic trip;
        trip    = 1'b0;
        olim    = (cfg_now.output_limit > DUTY_LIMIT) ? DUTY_LIMIT : int'(cfg_now.output_limit);
        sd      = (cfg_now.stop_duty > DUTY_LIMIT) ? DUTY_LIMIT : int'(cfg_now.stop_duty);
        spd_thr = int'($signed(cfg_now.stall_speed_threshold));
        case (it.op)
            dmss_pkg::OpDrive: begin
                if (g_stop) begin
                    // stopped: only the duties move, to the stop level
                    g_duty_l = 14'(sd);
                    g_duty_r = 14'(sd);
                end else begin
                    l = int'($signed(it.lcmd));
                    r = int'($signed(it.rcmd));
                    if (l > olim) l = olim; else if (l < -olim) l = -olim;
                    if (r > olim) r = olim; else if (r < -olim) r = -olim;
                    // ramp first, then the optional pair limit; zero skips a limit
                    for (k = 0; k < 2; k++) begin
                        lim = (k == 0) ? int'(g_ramp) : int'(cfg_now.second_limit);
                        la  = (l < 0) ? -l : l;
                        ra  = (r < 0) ? -r : r;
                        mx  = (la > ra) ? la : ra;
                        if (lim != 0 && mx > lim) begin
                            l = (l * lim) / mx;
                            r = (r * lim) / mx;
                        end
                    end
                    if (l == 0 && r == 0) begin
                        g_ramp  = cfg_now.ramp_initial;
                        g_cnt_l = '0;
                        g_cnt_r = '0;
                    end else if (int'(g_ramp) < olim) begin
                        grown  = int'(g_ramp) + int'(cfg_now.ramp_step);
                        g_ramp = 14'((grown > olim) ? olim : grown);
                    end
                    g_last_l = 15'(l);
                    g_last_r = 15'(r);
                    if (l > 0) g_pin_l = 1'b1; else if (l < 0) g_pin_l = 1'b0;
                    if (r > 0) g_pin_r = 1'b0; else if (r < 0) g_pin_r = 1'b1;
                    g_duty_l = 14'((l < 0) ? -l : l);
                    g_duty_r = 14'((r < 0) ? -r : r);
                end
            end
            dmss_pkg::OpStall: begin
                if (g_ramp < cfg_now.stall_duty_threshold) begin
                    g_cnt_l = '0;
                    g_cnt_r = '0;
                end else begin
                    la = (g_last_l < 0) ? -int'(g_last_l) : int'(g_last_l);
                    ra = (g_last_r < 0) ? -int'(g_last_r) : int'(g_last_r);
                    if (la > int'(cfg_now.stall_duty_threshold) &&
                        int'($signed(it.lspd)) < spd_thr) begin
                        if (g_cnt_l < dmss_pkg::CntMax) g_cnt_l = g_cnt_l + 7'd1;
                    end else begin
                        g_cnt_l = '0;
                    end
                    if (ra > int'(cfg_now.stall_duty_threshold) &&
                        int'($signed(it.rspd)) < spd_thr) begin
                        if (g_cnt_r < dmss_pkg::CntMax) g_cnt_r = g_cnt_r + 7'd1;
                    end else begin
                        g_cnt_r = '0;
                    end
                    if (g_cnt_l >= cfg_now.stall_confirm || g_cnt_r >= cfg_now.stall_confirm) begin
                        g_stop  = 1'b1;
                        g_cnt_l = '0;
                        g_cnt_r = '0;
                        trip    = 1'b1;
                    end
                end
            end
            dmss_pkg::OpStop: begin
                g_stop = 1'b1;
            end
            default: begin
            end
        endcase
        res.left_duty  = g_duty_l;
        res.left_dir   = g_pin_l;
        res.right_duty = g_duty_r;
        res.right_dir  = g_pin_r;
        res.stopped    = g_stop;
        res.trip       = trip;
        res.ramp       = g_ramp;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Queue one item; fields its op does not use get random content.
    task automatic offer(input logic [1:0] op, input int a, input int b);
        t_guard_item it;
        it.op   = op;
        it.lcmd = 16'($urandom);
        it.rcmd = 16'($urandom);
        it.lspd = 16'($urandom);
        it.rspd = 16'($urandom);
        if (op == dmss_pkg::OpDrive) begin
            it.lcmd = 16'(a);
            it.rcmd = 16'(b);
        end else if (op == dmss_pkg::OpStall) begin
            it.lspd = 16'(a);
            it.rspd = 16'(b);
        end
        cmd_backlog.push_back(it);
        n_issued++;
        // Outside the trip phases, drop both stall counters with a fast-wheel
        // tick before any confirm count can be reached.
        if (op == dmss_pkg::OpStall && keep_clear) begin
            since_clear++;
            if (since_clear >= CLEAR_RUN) begin
                it.lspd = 16'sh7FFF;
                it.rspd = 16'sh7FFF;
                cmd_backlog.push_back(it);
                n_issued++;
                since_clear = 0;
            end
        end
    endtask

    function automatic int pick_cmd();
        case ($urandom_range(0, 7))
            0:       return int'($urandom_range(0, 65535)) - 32768;
            1:       return 32767;
            2:       return -32768;
            3, 4:    return int'($urandom_range(0, 22000)) - 11000;
            5:       return int'($urandom_range(0, 600)) - 300;
            default: return int'($urandom_range(0, 12000)) - 6000;
        endcase
    endfunction

    function automatic int big_cmd();
        int v;
        v = int'($urandom_range(6000, 32767));
        return ($urandom_range(0, 1) != 0) ? v : -v;
    endfunction

    // Speed mostly just below the current threshold, sometimes fully random
    function automatic int low_speed();
        int hi, span;
        hi = int'($signed(cfg_now.stall_speed_threshold)) - 1;
        if (hi < -32768 || $urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        span = hi + 32768;
        if (span > 400) span = 400;
        return hi - int'($urandom_range(0, span));
    endfunction

    function automatic int pick_speed();
        case ($urandom_range(0, 5))
            0:       return int'($urandom_range(0, 65535)) - 32768;
            1:       return 32767;
            2:       return -32768;
            3:       return int'($signed(cfg_now.stall_speed_threshold)) +
                            int'($urandom_range(0, 40)) - 20;
            default: return low_speed();
        endcase
    endfunction

    // Mostly drive-then-ticks sequences, so the stall counters actually climb
    task automatic random_mix(input int n, input bit with_stop);
        int start, r, k, j;
        start = n_issued;
        while (n_issued - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                offer(dmss_pkg::OpDrive, big_cmd(), big_cmd());
                k = $urandom_range(1, 8);
                for (j = 0; j < k; j++)
                    offer(dmss_pkg::OpStall,
                          ($urandom_range(0, 3) != 0) ? low_speed() : pick_speed(),
                          ($urandom_range(0, 3) != 0) ? low_speed() : pick_speed());
                if (with_stop && $urandom_range(0, 9) == 0) offer(dmss_pkg::OpStop, 0, 0);
            end else if (r < 68) begin
                offer(dmss_pkg::OpDrive, pick_cmd(), pick_cmd());
            end else if (r < 78) begin
                offer(dmss_pkg::OpStall, pick_speed(), pick_speed());
            end else if (r < 84) begin
                offer(dmss_pkg::OpDrive, 0, ($urandom_range(0, 1) != 0) ? 0 : pick_cmd());
            end else if (r < 88) begin
                offer(OpUnused, 0, 0);
            end else if (r < 94 && with_stop) begin
                offer(dmss_pkg::OpStop, 0, 0);
            end else begin
                offer(dmss_pkg::OpDrive, int'($urandom_range(0, 40)) - 20,
                      int'($urandom_range(0, 40)) - 20);
            end
        end
    endtask

    // Setup cycle, then access cycle; the register takes the data on the
    // access edge once pready is seen.
    task automatic apb_write(input logic [2:0] idx, input logic [dmss_pkg::DataW-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dmss_pkg::AddrW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dmss_pkg::RegOutLim:
                cfg_now.output_limit          = val[dmss_pkg::MagW-1:0];
            dmss_pkg::RegSecLim:
                cfg_now.second_limit          = val[dmss_pkg::MagW-1:0];
            dmss_pkg::RegRampInit:
                cfg_now.ramp_initial          = val[dmss_pkg::MagW-1:0];
            dmss_pkg::RegRampStep:
                cfg_now.ramp_step             = val[dmss_pkg::StepW-1:0];
            dmss_pkg::RegStallDuty:
                cfg_now.stall_duty_threshold  = val[dmss_pkg::MagW-1:0];
            dmss_pkg::RegStallSpd:
                cfg_now.stall_speed_threshold = val[dmss_pkg::SpeedW-1:0];
            dmss_pkg::RegConfirm:
                cfg_now.stall_confirm         = val[dmss_pkg::CntW-1:0];
            dmss_pkg::RegStopDuty:
                cfg_now.stop_duty             = val[dmss_pkg::MagW-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_cfg(input int ol, input int sl, input int ri, input int rs,
                            input int sdt, input int sst, input int conf, input int sd);
        apb_write(dmss_pkg::RegOutLim,    dmss_pkg::DataW'(ol));
        apb_write(dmss_pkg::RegSecLim,    dmss_pkg::DataW'(sl));
        apb_write(dmss_pkg::RegRampInit,  dmss_pkg::DataW'(ri));
        apb_write(dmss_pkg::RegRampStep,  dmss_pkg::DataW'(rs));
        apb_write(dmss_pkg::RegStallDuty, dmss_pkg::DataW'(sdt));
        apb_write(dmss_pkg::RegStallSpd,  dmss_pkg::DataW'(sst));
        apb_write(dmss_pkg::RegConfirm,   dmss_pkg::DataW'(conf));
        apb_write(dmss_pkg::RegStopDuty,  dmss_pkg::DataW'(sd));
    endtask

    // Hold until every queued item has gone in and every result has come out.
    task automatic wait_idle();
        while (n_accepted != n_issued || outputs_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: bursts of items separated by random gaps, some gaps empty.
    // Change valid only when the slot is free, so a pending item stays put.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap     <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                tx_item        = cmd_backlog.pop_front();
                i_op          <= tx_item.op;
                i_left_cmd    <= tx_item.lcmd;
                i_right_cmd   <= tx_item.rcmd;
                i_left_speed  <= tx_item.lspd;
                i_right_speed <= tx_item.rspd;
                i_in_valid    <= 1'b1;
                if (tx_burst <= 1) begin
                    tx_burst <= $urandom_range(1, 16);
                    tx_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    tx_burst <= tx_burst - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus while items are still queued
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Receiver: stall pattern picked at random from four - always ready, coin toss,
    // ready a quarter of the time, or ready two thirds of the time.
    always @(negedge i_clk) begin
        logic rdy;
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 1) != 0);
            2:       rdy = (rx_cycle % 4 == 0);
            default: rdy = (rx_cycle % 3 != 0);
        endcase
        i_out_ready <= rdy && (hold_left == 0);
    end

    // Monitor: check each accepted result against the oldest prediction, then
    // predict the result of any item taken at this edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outputs_due.size() == 0) begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t ns: result with no item outstanding", $time);
            end else begin
                rx_want = outputs_due.pop_front();
                n_checked++;
                check_field("left_duty",     16'(rx_want.left_duty),  16'(o_left_duty));
                check_field("left_dir_pin",  16'(rx_want.left_dir),   16'(o_left_dir_pin));
                check_field("right_duty",    16'(rx_want.right_duty), 16'(o_right_duty));
                check_field("right_dir_pin", 16'(rx_want.right_dir),  16'(o_right_dir_pin));
                check_field("stopped",       16'(rx_want.stopped),    16'(o_stopped));
                check_field("stall_trip",    16'(rx_want.trip),       16'(o_stall_trip));
                check_field("ramp_now",      16'(rx_want.ramp),       16'(o_ramp_now));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            rx_in.op   = i_op;
            rx_in.lcmd = i_left_cmd;
            rx_in.rcmd = i_right_cmd;
            rx_in.lspd = i_left_speed;
            rx_in.rspd = i_right_speed;
            rx_want    = guard_advance(rx_in);
            outputs_due.push_back(rx_want);
            n_accepted++;
            case (i_op)
                dmss_pkg::OpDrive: n_drive++;
                dmss_pkg::OpStall: n_tick++;
                dmss_pkg::OpStop:  n_stop_req++;
                default:           n_unused++;
            endcase
            if (rx_want.trip) n_trips++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycles, outputs_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at reset settings: command extremes, clamp and ramp
        // scaling, all-zero output, held pins, unused op, gated stall ticks.
        offer(dmss_pkg::OpDrive, 32767, -32768);
        offer(dmss_pkg::OpDrive, -32768, 32767);
        offer(dmss_pkg::OpDrive, 0, 0);
        offer(dmss_pkg::OpDrive, 100, -50);
        offer(dmss_pkg::OpDrive, -1, 1);
        offer(dmss_pkg::OpDrive, 5000, 2500);
        offer(dmss_pkg::OpDrive, -9001, 9000);
        offer(dmss_pkg::OpDrive, 0, 7000);
        offer(dmss_pkg::OpDrive, -7000, 0);
        offer(OpUnused, 0, 0);
        offer(dmss_pkg::OpStall, -32768, 32767);
        offer(dmss_pkg::OpStall, 32767, -32768);
        offer(dmss_pkg::OpDrive, 0, 0);
        offer(dmss_pkg::OpDrive, 3000, -3001);
        wait_idle();

        // Zero ramp start, largest step, speed threshold at zero
        load_cfg(10000, 0, 0, 1023, 2000, 0, 127, 0);
        random_mix(80, 1'b0);
        wait_idle();

        // Tight clamp with pair limit, ramp frozen, no speed ever low enough
        load_cfg(4000, 2500, 500, 0, 0, -32768, 40, 10000);
        random_mix(60, 1'b0);
        wait_idle();

        // Zero output limit: every duty collapses to zero
        load_cfg(0, 10000, 10000, 5, 100, 100, 21, 50);
        random_mix(20, 1'b0);
        wait_idle();

        // Limits above full scale saturate; ramp parked above the clamp
        load_cfg(16383, 10000, 16383, 1, 10000, 32767, 1, 16383);
        random_mix(50, 1'b0);
        wait_idle();

        // Counting stall ticks below the confirm level, under a long output hold-off
        load_cfg(9000, 7000, 6000, 200, 5000, 64, 25, 100);
        random_mix(90, 1'b0);
        hold_req = 1'b1;
        wait_idle();

        // Stop request, then a stall trip reported while already stopped
        keep_clear = 1'b0;
        load_cfg(9000, 0, 8000, 48, 3000, 32, 5, 100);
        offer(dmss_pkg::OpDrive, 9000, -9000);
        offer(dmss_pkg::OpStall, 10, 20);
        offer(dmss_pkg::OpStall, -40, 31);
        offer(dmss_pkg::OpStall, -32768, 0);
        offer(dmss_pkg::OpStop, 0, 0);
        offer(dmss_pkg::OpDrive, 1234, -4321);
        offer(dmss_pkg::OpStall, 31, -1);
        offer(dmss_pkg::OpStall, 0, 0);
        offer(dmss_pkg::OpDrive, 0, 0);
        random_mix(50, 1'b1);
        wait_idle();

        // Zero confirm count: every gated tick trips; stop duty saturates
        load_cfg(10000, 10000, 0, 1023, 0, -32768, 0, 16383);
        random_mix(30, 1'b1);
        wait_idle();

        repeat (100) @(posedge i_clk);
        $display("Checked %0d results from %0d items: %0d drive, %0d stall tick, %0d stop, %0d unused op",
                 n_checked, n_accepted, n_drive, n_tick, n_stop_req, n_unused);
        $display("Eight register settings from zero to beyond full scale, %0d stall trips, %0d mismatches",
                 n_trips, err_count);
        if (err_count == 0 && outputs_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[dual_motor_soft_start_stall_guard_core.f]
+incdir+rtl
rtl/dmss_pkg.sv
rtl/dmss_cfg_regs.sv
rtl/dmss_muldiv.sv
rtl/dual_motor_soft_start_stall_guard_core.sv
sim/dual_motor_soft_start_stall_guard_core_tb.sv
